@@ rtl/sebi_pkg.sv @@
`timescale 1ns / 1ps
package sebi_pkg;
  localparam int MaxChains = 8;
  localparam int MaxExtents = 64;
  localparam int NumSlots = 4;
  localparam int ChW = $clog2(MaxChains);
  localparam int ExW = $clog2(MaxExtents);
  localparam int CntW = $clog2(MaxChains + 1);
  localparam int ExCntW = $clog2(MaxExtents + 1);
  localparam int SlotW = $clog2(NumSlots);

  typedef enum logic [2:0] {
    KIND_ADD     = 3'd0,
    KIND_APPEND  = 3'd1,
    KIND_REWIND  = 3'd2,
    KIND_NEXT    = 3'd3,
    KIND_SAVE    = 3'd4,
    KIND_RESTORE = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BADHDL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] chain_id;
    logic signed [15:0] priority_req;
    logic [6:0] page_blocks;
    logic [3:0] block_shift;
    logic [31:0] extent_start;
    logic [31:0] extent_end;
    logic striped;
    logic [1:0] slot;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic position_valid;
    logic [2:0] current_chain_id;
    logic [31:0] block_number;
    logic [46:0] sector_address;
  } out_item_t;

  typedef struct packed {
    logic [ExCntW-1:0] ext;
    logic [31:0] offset;
  } cursor_t;
endpackage

@@ rtl/sebi_if.sv @@
`timescale 1ns / 1ps
interface sebi_in_if;
  logic valid;
  logic ready;
  sebi_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sebi_out_if;
  logic valid;
  logic ready;
  sebi_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/striped_extent_block_iterator.sv @@
`timescale 1ns / 1ps
// channel  direction  payload
// in_i     sink       kind, chain_id, priority_req, page_blocks, block_shift,
//                     extent_start, extent_end, striped, slot
// out_o    source     status, position_valid, current_chain_id, block_number,
//                     sector_address
// one item at a time; the next item waits until the held result is taken
// after accept: add and append go straight to the result; save and restore
//   of a valid position visit each chain once; rewind reads each chain's first extent
// next page: walks the page block by block, with an extra read when crossing
//   into the next extent, then a rotation scan if striped or the chain ran out
// reset clears control and cursors at once, no clearing pass
module striped_extent_block_iterator (
  input logic clk_i,
  input logic rst_ni,
  sebi_in_if.sink in_i,
  sebi_out_if.source out_o
);
  localparam int ChW = sebi_pkg::ChW;
  localparam int ExW = sebi_pkg::ExW;
  localparam int CntW = sebi_pkg::CntW;
  localparam int ExCntW = sebi_pkg::ExCntW;
  localparam int MemAw = ChW + ExW;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_ADD    = 10'b0000000010,
    S_RW     = 10'b0000000100,
    S_RWWAIT = 10'b0000001000,
    S_STEP   = 10'b0000010000,
    S_SWAIT  = 10'b0000100000,
    S_ROT    = 10'b0001000000,
    S_ROT2   = 10'b0010000000,
    S_SR     = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  sebi_pkg::in_item_t it_q;

  // extent memory, lo and hi in one word
  logic [63:0] ext_mem [2**MemAw];
  logic [63:0] rd_q;
  logic [MemAw-1:0] raddr;
  logic ren, wen;
  logic [MemAw-1:0] waddr;
  logic [63:0] wdata;

  // per-chain registers
  logic [ChW-1:0] order_q [sebi_pkg::MaxChains];
  logic signed [15:0] prio_q [sebi_pkg::MaxChains];
  logic [6:0] bpp_q [sebi_pkg::MaxChains];
  logic [3:0] shift_q [sebi_pkg::MaxChains];
  logic [ExCntW-1:0] cnt_q [sebi_pkg::MaxChains];
  sebi_pkg::cursor_t cur_q [sebi_pkg::MaxChains];
  sebi_pkg::cursor_t saved_q [sebi_pkg::NumSlots][sebi_pkg::MaxChains];
  logic signed [4:0] snum_q [sebi_pkg::NumSlots];
  logic [CntW-1:0] ccount_q;
  logic cvalid_q;
  logic [ChW-1:0] cchain_q;

  logic [CntW-1:0] idx_q;
  logic [CntW-1:0] start_q, found_q;
  logic [6:0] steps_q;
  logic [1:0] status_q;
  logic ovalid_q;
  sebi_pkg::out_item_t odata_q;

  logic in_acc;
  assign in_i.ready = (state_q == S_IDLE) && !ovalid_q;
  assign in_acc = in_i.valid && in_i.ready;
  assign out_o.valid = ovalid_q;
  assign out_o.data = odata_q;

  always_ff @(posedge clk_i) begin
    if (wen) ext_mem[waddr] <= wdata;
    if (ren) rd_q <= ext_mem[raddr];
  end

  logic [ChW-1:0] ih;
  logic [ChW-1:0] nxt_p, p_h, f_h;
  logic [CntW-1:0] nxt_idx;
  sebi_pkg::cursor_t cc;
  assign ih = it_q.chain_id[ChW-1:0];
  assign cc = cur_q[cchain_q];
  assign p_h = order_q[idx_q[ChW-1:0]];
  assign f_h = order_q[found_q[ChW-1:0]];
  assign nxt_idx = (idx_q + CntW'(1) >= ccount_q) ? '0 : idx_q + CntW'(1);
  assign nxt_p = order_q[nxt_idx[ChW-1:0]];

  always_comb begin
    ren = 1'b0;
    raddr = {cchain_q, ExW'(cc.ext - ExCntW'(1))};
    wen = 1'b0;
    waddr = {ih, cnt_q[ih][ExW-1:0]};
    wdata = {it_q.extent_end, it_q.extent_start};
    if (state_q == S_ADD && it_q.kind == sebi_pkg::KIND_APPEND &&
        CntW'(it_q.chain_id) < ccount_q &&
        cnt_q[ih] < ExCntW'(sebi_pkg::MaxExtents)) wen = 1'b1;
    if (state_q == S_RW) begin
      ren = 1'b1;
      raddr = {idx_q[ChW-1:0], ExW'(0)};
    end
    if (state_q == S_STEP) begin
      ren = 1'b1;
      if (cc.ext != '0 && cc.ext < cnt_q[cchain_q] && steps_q != '0 && rd_q[63:32] == cc.offset
          && idx_q[0])
        raddr = {cchain_q, cc.ext[ExW-1:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ccount_q <= '0;
      cvalid_q <= 1'b0;
      cchain_q <= '0;
      ovalid_q <= 1'b0;
      for (int i = 0; i < sebi_pkg::MaxChains; i++) begin
        cur_q[i] <= '0;
        cnt_q[i] <= '0;
        for (int s = 0; s < sebi_pkg::NumSlots; s++) saved_q[s][i] <= '0;
      end
      for (int s = 0; s < sebi_pkg::NumSlots; s++) snum_q[s] <= '0;
    end else begin
      if (out_o.valid && out_o.ready) ovalid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (in_acc) begin
          it_q <= in_i.data;
          status_q <= sebi_pkg::ST_OK;
          idx_q <= '0;
          state_q <= S_ADD;
        end
        S_ADD: begin
          state_q <= S_DONE;
          if (it_q.kind == sebi_pkg::KIND_ADD) begin
            if (ccount_q >= CntW'(sebi_pkg::MaxChains) ||
                CntW'(it_q.chain_id) != ccount_q) status_q <= sebi_pkg::ST_BADHDL;
            else begin
              prio_q[ih] <= it_q.priority_req;
              bpp_q[ih] <= it_q.page_blocks;
              shift_q[ih] <= it_q.block_shift;
              cnt_q[ih] <= '0;
              cur_q[ih] <= '0;
              for (int q = 0; q < sebi_pkg::MaxChains; q++) begin
                if (CntW'(q) < ccount_q) begin
                  if (prio_q[order_q[q]] < it_q.priority_req && q + 1 < sebi_pkg::MaxChains)
                    order_q[q + 1] <= order_q[q];
                end
              end
              begin : ins
                logic [CntW-1:0] pos;
                pos = ccount_q;
                for (int q = sebi_pkg::MaxChains - 1; q >= 0; q--)
                  if (CntW'(q) < ccount_q && prio_q[order_q[q]] < it_q.priority_req)
                    pos = CntW'(q);
                order_q[pos[ChW-1:0]] <= ih;
              end
              ccount_q <= ccount_q + CntW'(1);
            end
          end else if (it_q.kind == sebi_pkg::KIND_APPEND) begin
            if (wen) begin
              cnt_q[ih] <= cnt_q[ih] + ExCntW'(1);
              if (cnt_q[ih] == '0) cur_q[ih] <= '{ext: ExCntW'(1), offset: it_q.extent_start};
            end else status_q <= sebi_pkg::ST_BADHDL;
          end else if (it_q.kind == sebi_pkg::KIND_REWIND) begin
            if (ccount_q != '0) state_q <= S_RW;
            cvalid_q <= ccount_q != '0;
            cchain_q <= ccount_q != '0 ? order_q[0] : '0;
          end else if (it_q.kind == sebi_pkg::KIND_NEXT) begin
            if (!cvalid_q) status_q <= sebi_pkg::ST_NOSPACE;
            else begin
              steps_q <= bpp_q[cchain_q];
              state_q <= S_SWAIT;
            end
          end else if (it_q.kind == sebi_pkg::KIND_SAVE ||
                       it_q.kind == sebi_pkg::KIND_RESTORE) begin
            if (it_q.kind == sebi_pkg::KIND_SAVE && !cvalid_q) snum_q[it_q.slot] <= -5'sd1;
            else if (it_q.kind == sebi_pkg::KIND_RESTORE && snum_q[it_q.slot] == -5'sd1)
              cvalid_q <= 1'b0;
            else if (ccount_q != '0) state_q <= S_SR;
          end
        end
        S_RW: state_q <= S_RWWAIT;
        S_RWWAIT: begin
          if (cnt_q[idx_q[ChW-1:0]] != '0)
            cur_q[idx_q[ChW-1:0]] <= '{ext: ExCntW'(1), offset: rd_q[31:0]};
          else cur_q[idx_q[ChW-1:0]].ext <= '0;
          idx_q <= idx_q + CntW'(1);
          state_q <= (idx_q + CntW'(1) >= ccount_q) ? S_DONE : S_RW;
        end
        S_SWAIT: begin
          state_q <= S_STEP;
        end
        S_STEP: begin
          // even phase reads hi; odd phase acts (lo read in flight if needed)
          if (steps_q == '0 || cc.ext == '0 || cc.ext > cnt_q[cchain_q]) begin
            start_q <= '0;
            for (int q = 0; q < sebi_pkg::MaxChains; q++)
              if (CntW'(q) < ccount_q && order_q[q] == cchain_q) start_q <= CntW'(q);
            state_q <= S_ROT;
          end else if (!idx_q[0]) idx_q <= CntW'(1);
          else if (rd_q[63:32] == cc.offset) begin
            if (cc.ext < cnt_q[cchain_q]) begin
              cur_q[cchain_q].ext <= cc.ext + ExCntW'(1);
              idx_q <= CntW'(2);
              state_q <= S_SWAIT;
            end else begin
              cur_q[cchain_q] <= '0;
              steps_q <= steps_q - 7'd1;
              idx_q <= '0;
            end
          end else begin
            cur_q[cchain_q].offset <= cc.offset + 32'd1;
            steps_q <= steps_q - 7'd1;
            idx_q <= '0;
          end
          if (state_q == S_STEP && idx_q == CntW'(2)) begin
            // lo of new extent arrived
            cur_q[cchain_q].offset <= rd_q[31:0];
            steps_q <= steps_q - 7'd1;
            idx_q <= '0;
            state_q <= S_STEP;
          end
        end
        S_ROT: begin
          if (!(it_q.striped || cc.ext == '0)) state_q <= S_DONE;
          else begin
            idx_q <= start_q;
            found_q <= start_q;
            state_q <= S_ROT2;
            if (ccount_q == CntW'(1)) idx_q <= start_q;
            steps_q <= 7'd1;
          end
        end
        S_ROT2: begin
          if (steps_q == 7'd1) begin
            if (nxt_idx == start_q) steps_q <= '0;
            else if (cur_q[nxt_p].ext != '0 && prio_q[nxt_p] == prio_q[cchain_q]) begin
              found_q <= nxt_idx;
              steps_q <= '0;
            end else idx_q <= nxt_idx;
          end else begin
            if (found_q >= ccount_q) begin
              cvalid_q <= 1'b0;
              status_q <= sebi_pkg::ST_NOSPACE;
              state_q <= S_DONE;
            end else if (cur_q[f_h].ext == '0) found_q <= found_q + CntW'(1);
            else begin
              cchain_q <= f_h;
              state_q <= S_DONE;
            end
          end
        end
        S_SR: begin
          if (it_q.kind == sebi_pkg::KIND_SAVE) begin
            saved_q[it_q.slot][p_h] <= cur_q[p_h];
            if (p_h == cchain_q) snum_q[it_q.slot] <= 5'(idx_q) + 5'sd1;
          end else begin
            if (saved_q[it_q.slot][p_h].ext > cnt_q[p_h]) begin
              cur_q[p_h].ext <= '0;
              cur_q[p_h].offset <= saved_q[it_q.slot][p_h].offset;
            end else cur_q[p_h] <= saved_q[it_q.slot][p_h];
            if (5'(idx_q) + 5'sd1 == snum_q[it_q.slot]) begin
              cvalid_q <= 1'b1;
              cchain_q <= p_h;
            end
          end
          idx_q <= idx_q + CntW'(1);
          if (idx_q + CntW'(1) >= ccount_q) state_q <= S_DONE;
        end
        S_DONE: begin
          ovalid_q <= 1'b1;
          odata_q.status <= status_q;
          odata_q.position_valid <= cvalid_q;
          odata_q.current_chain_id <= cvalid_q ? 3'(cchain_q) : '0;
          odata_q.block_number <= cvalid_q ? cc.offset : '0;
          odata_q.sector_address <= cvalid_q ? 47'({15'd0, cc.offset} << shift_q[cchain_q]) : '0;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ccount_q <= CntW'(sebi_pkg::MaxChains)) else $error("chain count overflow");
  a_outhold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && !out_o.ready |=> ovalid_q) else $error("result dropped");
`endif
endmodule
